[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each takes a label, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/tpw_pkg.sv]
package tpw_pkg;

  localparam int RF_W    = 30;
  localparam int IF_W    = 27;
  localparam int NUM_W   = 31;  // holds rf + if + half step without overflow
  localparam int REM_W   = 18;  // holds the largest reference step
  localparam int N_CELLS = NUM_W;
  localparam int WORD_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int SEL_W   = 2;
  localparam int TOP_W   = 3;
  localparam int IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    CFG_REF_STEP_SEL        = 3'd0,
    CFG_IF_FREQ_HZ          = 3'd1,
    CFG_EXT_AGC_EN          = 3'd2,
    CFG_EXT_DISABLE_CURRENT = 3'd3,
    CFG_AGC_TOP_SEL         = 3'd4
  } cfg_index_t;

  typedef enum logic [SEL_W-1:0] {
    STEP_50K  = 2'd0,
    STEP_62K5 = 2'd1,
    STEP_166K = 2'd2,
    STEP_SPARE = 2'd3
  } step_sel_t;

  localparam logic [BYTE_W-1:0] REF_BYTE_50K  = 8'hCB;
  localparam logic [BYTE_W-1:0] REF_BYTE_62K5 = 8'hC8;
  localparam logic [BYTE_W-1:0] REF_BYTE_166K = 8'hCA;
  localparam logic [BYTE_W-1:0] SAW_8MHZ      = 8'h08;
  localparam logic [BYTE_W-1:0] AGC_INT_BASE  = 8'h80;
  localparam logic [BYTE_W-1:0] AGC_EXT_OFF   = 8'h86;
  localparam logic [BYTE_W-1:0] AGC_EXT_ON    = 8'h87;
  localparam logic [TOP_W-1:0]  AGC_TOP_MAX   = 3'd5;

  localparam logic [BYTE_W-1:0] PUMP_LOW  = 8'h40;
  localparam logic [BYTE_W-1:0] PUMP_A    = 8'h60;
  localparam logic [BYTE_W-1:0] PUMP_B    = 8'hA0;
  localparam logic [BYTE_W-1:0] PUMP_C    = 8'hC0;
  localparam logic [BYTE_W-1:0] PUMP_D    = 8'hE0;
  localparam logic [BYTE_W-1:0] BAND_LOW  = 8'h01;
  localparam logic [BYTE_W-1:0] BAND_MID  = 8'h02;
  localparam logic [BYTE_W-1:0] BAND_HIGH = 8'h04;

  typedef struct packed {
    logic [SEL_W-1:0] ref_step_sel;
    logic [IF_W-1:0]  if_freq_hz;
    logic             ext_agc_en;
    logic             ext_disable_current;
    logic [TOP_W-1:0] agc_top_sel;
  } cfg_t;

  // One stage of the divider chain: partial remainder, dividend bits still to be
  // consumed with quotient bits shifted in behind them, and the side bytes.
  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  rem;
    logic [NUM_W-1:0]  dq;
    logic [SEL_W-1:0]  sel;
    logic [BYTE_W-1:0] agc;
    logic [BYTE_W-1:0] ctrl;
  } cell_t;

  function automatic logic [REM_W-1:0] step_divisor(input logic [SEL_W-1:0] sel);
    logic [REM_W-1:0] d;
    unique case (sel)
      STEP_50K:  d = 18'd50000;
      STEP_62K5: d = 18'd62500;
      default:   d = 18'd166670;
    endcase
    return d;
  endfunction

  function automatic logic [NUM_W-1:0] half_step(input logic [SEL_W-1:0] sel);
    logic [REM_W-1:0] d;
    d = step_divisor(sel);
    return {{(NUM_W-REM_W){1'b0}}, 1'b0, d[REM_W-1:1]};
  endfunction

  function automatic logic [BYTE_W-1:0] ref_byte(input logic [SEL_W-1:0] sel);
    logic [BYTE_W-1:0] b;
    unique case (sel)
      STEP_50K:  b = REF_BYTE_50K;
      STEP_62K5: b = REF_BYTE_62K5;
      default:   b = REF_BYTE_166K;
    endcase
    return b;
  endfunction

  function automatic logic in_band(input logic [NUM_W-1:0] v, input int unsigned lo,
                                   input int unsigned hi);
    return (v >= NUM_W'(lo)) && (v < NUM_W'(hi));
  endfunction

  function automatic logic [BYTE_W-1:0] pump_bits(input logic [NUM_W-1:0] osc);
    logic [BYTE_W-1:0] p;
    priority if (in_band(osc, 87000000, 130000000) || in_band(osc, 200000000, 290000000) ||
                 in_band(osc, 480000000, 620000000)) begin
      p = PUMP_A;
    end else if (in_band(osc, 130000000, 160000000) ||
                 in_band(osc, 290000000, 420000000) ||
                 in_band(osc, 620000000, 830000000)) begin
      p = PUMP_B;
    end else if (in_band(osc, 160000000, 200000000) ||
                 in_band(osc, 420000000, 480000000)) begin
      p = PUMP_C;
    end else if (in_band(osc, 830000000, 900000000)) begin
      p = PUMP_D;
    end else begin
      p = PUMP_LOW;
    end
    return p;
  endfunction

  function automatic logic [BYTE_W-1:0] band_bits(input logic [RF_W-1:0] rf);
    logic [BYTE_W-1:0] b;
    priority if ((rf >= RF_W'(49000000)) && (rf < RF_W'(162000000))) begin
      b = BAND_LOW;
    end else if ((rf >= RF_W'(162000000)) && (rf < RF_W'(448000000))) begin
      b = BAND_MID;
    end else begin
      b = BAND_HIGH;
    end
    return b;
  endfunction

endpackage

[rtl/tpw_if.sv]
interface tpw_req_if import tpw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RF_W-1:0] rf_freq_hz;

  modport source (output valid, output rf_freq_hz, input ready);
  modport sink (input valid, input rf_freq_hz, output ready);
endinterface

interface tpw_res_if import tpw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] divider_word;
  logic [BYTE_W-1:0] ref_control_byte;
  logic [BYTE_W-1:0] agc_control_byte;
  logic [BYTE_W-1:0] band_control_byte;
  logic              divider_saturated;

  modport source (output valid, output divider_word, output ref_control_byte,
                  output agc_control_byte, output band_control_byte,
                  output divider_saturated, input ready);
  modport sink (input valid, input divider_word, input ref_control_byte,
                input agc_control_byte, input band_control_byte,
                input divider_saturated, output ready);
endinterface

[rtl/tpw_entry.sv]
module tpw_entry import tpw_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [RF_W-1:0] rf_freq_hz,
  input  cfg_t            cfg,
  output cell_t           head
);

  logic              a_valid;
  logic [NUM_W-1:0]  a_osc;
  logic [BYTE_W-1:0] a_band;
  logic [SEL_W-1:0]  a_sel;
  logic [BYTE_W-1:0] a_agc;
  logic [BYTE_W-1:0] agc_next;
  cell_t             head_next;

  always_comb begin
    if (cfg.ext_agc_en) begin
      agc_next = cfg.ext_disable_current ? AGC_EXT_OFF : AGC_EXT_ON;
    end else if (cfg.agc_top_sel <= AGC_TOP_MAX) begin
      agc_next = AGC_INT_BASE | {{(BYTE_W-TOP_W){1'b0}}, cfg.agc_top_sel};
    end else begin
      agc_next = AGC_INT_BASE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
    if (adv) begin
      a_osc  <= NUM_W'(rf_freq_hz) + NUM_W'(cfg.if_freq_hz);
      a_band <= SAW_8MHZ | band_bits(rf_freq_hz);
      a_sel  <= cfg.ref_step_sel;
      a_agc  <= agc_next;
    end
  end

  // Rounding adds half a step before the divide.
  always_comb begin
    head_next.valid = a_valid;
    head_next.rem   = '0;
    head_next.dq    = a_osc + half_step(a_sel);
    head_next.sel   = a_sel;
    head_next.agc   = a_agc;
    head_next.ctrl  = pump_bits(a_osc) | a_band;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (adv) begin
      head <= head_next;
    end
  end

endmodule

[rtl/tpw_div_cell.sv]
module tpw_div_cell import tpw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  cell_t cur,
  output cell_t nxt
);

  logic [REM_W:0] trial;
  logic [REM_W:0] dvs;
  logic [REM_W:0] diff;
  logic           fits;
  cell_t          nxt_next;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {cur.rem, cur.dq[NUM_W-1]};
    dvs   = {1'b0, step_divisor(cur.sel)};
    diff  = trial - dvs;
    fits  = trial >= dvs;

    nxt_next      = cur;
    nxt_next.rem  = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
    nxt_next.dq   = {cur.dq[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nxt.valid <= 1'b0;
    end else if (adv) begin
      nxt <= nxt_next;
    end
  end

endmodule

[rtl/tuner_pll_word_generator.sv]
// Turns a requested RF frequency into the tuner PLL divider word and control bytes.
// A word is accepted every cycle unless the row is stopped, and is then registered in
// turn: two entry stages form the oscillator frequency and the rounded dividend, a row
// of 31 divider cells resolves one quotient bit each, and one output register holds
// the result. The whole row advances together and stops while the output register
// holds a word that has not been taken. Configuration writes take effect for words
// accepted after the write.
`include "assert_macros.svh"

module tuner_pll_word_generator import tpw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  tpw_req_if.sink          req,
  tpw_res_if.source        res,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [IF_W-1:0]  cfg_wdata
);

  cfg_t              cfg;
  logic              adv;
  cell_t             chain [N_CELLS+1];
  cell_t             last;
  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic [BYTE_W-1:0] out_ref;
  logic [BYTE_W-1:0] out_agc;
  logic [BYTE_W-1:0] out_ctrl;
  logic              out_sat;
  logic              sat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_step_sel        <= STEP_166K;
      cfg.if_freq_hz          <= IF_W'(36125000);
      cfg.ext_agc_en          <= 1'b0;
      cfg.ext_disable_current <= 1'b1;
      cfg.agc_top_sel         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF_STEP_SEL:        cfg.ref_step_sel        <= cfg_wdata[SEL_W-1:0];
        CFG_IF_FREQ_HZ:          cfg.if_freq_hz          <= cfg_wdata;
        CFG_EXT_AGC_EN:          cfg.ext_agc_en          <= cfg_wdata[0];
        CFG_EXT_DISABLE_CURRENT: cfg.ext_disable_current <= cfg_wdata[0];
        CFG_AGC_TOP_SEL:         cfg.agc_top_sel         <= cfg_wdata[TOP_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_valid || res.ready;
  assign req.ready = adv;

  tpw_entry u_entry (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (req.valid),
    .rf_freq_hz (req.rf_freq_hz),
    .cfg        (cfg),
    .head       (chain[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    tpw_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .cur (chain[i]),
      .nxt (chain[i+1])
    );
  end

  assign last = chain[N_CELLS];

  // Any quotient bit above the word width means the divider does not fit.
  assign sat_next = |last.dq[NUM_W-1:WORD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= last.valid;
    end
    if (adv) begin
      out_word <= sat_next ? {WORD_W{1'b1}} : last.dq[WORD_W-1:0];
      out_sat  <= sat_next;
      out_ref  <= ref_byte(last.sel);
      out_agc  <= last.agc;
      out_ctrl <= last.ctrl;
    end
  end

  assign res.valid             = out_valid;
  assign res.divider_word      = out_word;
  assign res.divider_saturated = out_sat;
  assign res.ref_control_byte  = out_ref;
  assign res.agc_control_byte  = out_agc;
  assign res.band_control_byte = out_ctrl;

  `ASSERT_SAME(a_sat_clamps, out_valid && out_sat, out_word == {WORD_W{1'b1}})
  `ASSERT_SAME(a_ctrl_format, out_valid,
               out_ctrl[3] && !out_ctrl[4] && (out_ctrl[7:5] != 3'd0) &&
               $onehot(out_ctrl[2:0]))
  `ASSERT_NEXT(a_chain_delivers, adv && last.valid, out_valid)
  `ASSERT_NEXT(a_stall_freezes_chain, !adv, $stable(last.valid) && $stable(chain[0].valid))

endmodule
